// File: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/cnlc_pkg.sv
package cnlc_pkg;

    localparam int NUM_W      = 63;            // binary card number width
    localparam int BCD_DIGITS = 19;            // decimal digits the input can hold
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_W     = $clog2(NUM_W); // step counter width
    localparam int CNT_W      = 5;             // digit count width

    // card classes
    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_LEAD4   = 2'd1;
    localparam logic [1:0] CLS_LEAD5X  = 2'd2;
    localparam logic [1:0] CLS_LEAD3X  = 2'd3;

    // lengths
    localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [CNT_W-1:0] LEN_16 = 5'd16;

    // leading digits
    localparam logic [3:0] DIG_1 = 4'd1;
    localparam logic [3:0] DIG_3 = 4'd3;
    localparam logic [3:0] DIG_4 = 4'd4;
    localparam logic [3:0] DIG_5 = 4'd5;
    localparam logic [3:0] DIG_7 = 4'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LUHN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;    // capture a new card number
        logic conv;    // one double-dabble step
        logic luhn;    // one Luhn digit step
        logic finish;  // classify and load the output register
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic luhn_last;
    } t_sts;

endpackage

// File: rtl/cnlc_ctrl.sv
`include "assert_macros.svh"

module cnlc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  cnlc_pkg::t_sts  i_sts,
    output cnlc_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);
    import cnlc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CONV;
            S_CONV: if (i_sts.conv_last) n_state = S_LUHN;
            S_LUHN: if (i_sts.luhn_last) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                cmd.load   = i_in_valid;
            end
            S_CONV: cmd.conv   = 1'b1;
            S_LUHN: cmd.luhn   = 1'b1;
            S_FIN:  cmd.finish = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `ASSERT_NEXT(a_fin_sets_valid, i_clk, i_rst_n, cmd.finish, r_out_valid && r_state == S_IDLE)
    `ASSERT_NEXT(a_conv_to_luhn, i_clk, i_rst_n, r_state == S_CONV && i_sts.conv_last, r_state == S_LUHN)
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall && !cmd.load)

endmodule

// File: rtl/cnlc_dp.sv
module cnlc_dp #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cnlc_pkg::t_cmd           i_cmd,
    input  logic [cnlc_pkg::NUM_W-1:0] i_card_number,
    output cnlc_pkg::t_sts           o_sts,
    output logic [1:0]               o_card_class,
    output logic                     o_luhn_ok,
    output logic [cnlc_pkg::CNT_W-1:0] o_digit_count
);
    import cnlc_pkg::*;

    logic [NUM_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd, bcd_adj;
    logic [STEP_W-1:0] r_step;
    logic [3:0]        r_sum, r_prev, r_first, r_second;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_class;
    logic              r_ok;
    logic [CNT_W-1:0]  r_count_out;

    logic [3:0]        dig;
    logic [4:0]        dig_dbl, dig_use, sum_raw, sum_mod;
    logic              too_long, sum_zero;
    logic [1:0]        cls;

    // add-3 on every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                           : r_bcd[4*k +: 4];
        end
    end

    assign o_sts.conv_last = i_cmd.conv && (r_step == STEP_W'(NUM_W - 1));
    assign o_sts.luhn_last = i_cmd.luhn && (r_step == STEP_W'(BCD_DIGITS - 1));

    // Luhn digit step, least significant digit first
    assign dig     = r_bcd[3:0];
    assign dig_dbl = (dig >= 4'd5) ? {dig, 1'b0} - 5'd9 : {dig, 1'b0};
    assign dig_use = r_step[0] ? dig_dbl : {1'b0, dig};
    assign sum_raw = {1'b0, r_sum} + dig_use;
    assign sum_mod = (sum_raw >= 5'd10) ? sum_raw - 5'd10 : sum_raw;

    // classification
    assign too_long = r_cnt > CNT_W'(MAX_DIGITS);
    assign sum_zero = r_sum == 4'd0;

    always_comb begin
        cls = CLS_INVALID;
        if (sum_zero && !too_long) begin
            if ((r_cnt == LEN_13 || r_cnt == LEN_16) && r_first == DIG_4) begin
                cls = CLS_LEAD4;
            end else if (r_cnt == LEN_16 && r_first == DIG_5
                         && r_second >= DIG_1 && r_second <= DIG_5) begin
                cls = CLS_LEAD5X;
            end else if (r_cnt == LEN_15 && r_first == DIG_3
                         && (r_second == DIG_4 || r_second == DIG_7)) begin
                cls = CLS_LEAD3X;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load || o_sts.conv_last) begin
            r_step <= '0;
        end else if (i_cmd.conv || i_cmd.luhn) begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin    <= i_card_number;
            r_bcd    <= '0;
            r_sum    <= '0;
            r_prev   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.conv) begin
            r_bin <= {r_bin[NUM_W-2:0], 1'b0};
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[NUM_W-1]};
        end else if (i_cmd.luhn) begin
            r_bcd  <= {4'd0, r_bcd[BCD_W-1:4]};
            r_sum  <= sum_mod[3:0];
            r_prev <= dig;
            if (dig != 4'd0) begin
                r_cnt    <= CNT_W'(r_step + 1'b1);
                r_first  <= dig;
                r_second <= r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_class     <= cls;
            r_ok        <= sum_zero && !too_long;
            r_count_out <= too_long ? CNT_W'(MAX_DIGITS) : r_cnt;
        end
    end

    assign o_card_class  = r_class;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_count_out;

endmodule

// File: rtl/card_number_luhn_classifier_core.sv
// Card number classifier: takes one 63-bit unsigned card number per input
// beat and returns one result beat with the decimal digit count, the Luhn
// mod-10 flag and the card class (0 invalid, 1 leading 4 with 13 or 16
// digits, 2 leading 51..55 with 16 digits, 3 leading 34/37 with 15 digits;
// a nonzero class needs a passing Luhn sum). Numbers longer than MAX_DIGITS
// report MAX_DIGITS digits, Luhn fail, class 0. One item is worked at a
// time: an accept step, 63 double-dabble steps (one binary bit per cycle
// into the BCD register), 19 Luhn steps (one decimal digit per cycle) and
// a finish step that loads the output register and waits while an earlier
// result is still held under stall. The result beat turns valid on the edge
// that returns the block to idle, and the next card is accepted from idle.
// A new card number is taken as soon as the block is idle, even while the
// previous result still waits under stall; the new item then converts,
// runs the Luhn pass and then waits in S_FIN until that result leaves.
module card_number_luhn_classifier_core #(
    parameter int MAX_DIGITS = 19   // 16..19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cnlc_pkg::NUM_W-1:0] i_card_number,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_card_class,
    output logic                       o_luhn_ok,
    output logic [cnlc_pkg::CNT_W-1:0] o_digit_count
);
    import cnlc_pkg::*;

    t_cmd cmd;   // controller -> datapath
    t_sts sts;   // datapath -> controller

    // sequencer: idle / convert / Luhn pass / finish
    cnlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // binary-to-BCD shifter, Luhn accumulator, classifier, result register
    cnlc_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_card_number (i_card_number),
        .o_sts         (sts),
        .o_card_class  (o_card_class),
        .o_luhn_ok     (o_luhn_ok),
        .o_digit_count (o_digit_count)
    );

endmodule
